FILE: src/pidtr_pkg.sv
package pidtr_pkg;

    localparam int TEMP_W   = 16;
    localparam int DUTY_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SP_W     = 13;
    localparam int GP_W     = 15;
    localparam int GI_W     = 12;
    localparam int GD_W     = 14;
    localparam int PERIOD_W = 16;

    localparam int ERR_W    = 17;
    localparam int DERR_W   = 18;
    localparam int INTEG_W  = 20;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 20;
    localparam int PROD_W   = 48;
    localparam int ACC_W    = 57;
    localparam int REM_W    = ACC_W - 12;
    localparam int DIV_STEPS = DUTY_W;
    localparam int DSOR_W   = PERIOD_W + DIV_STEPS - 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SP_W-1:0] SETPOINT_MIN = 13'd0;
    localparam logic [SP_W-1:0] SETPOINT_MAX = 13'd8000;
    localparam logic [SP_W-1:0] TARGET_RESET = 13'd1600;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 15'd25600;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 20'sd409600;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_VALID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_EP,
        OP_INTEG,
        OP_MUL_GPP,
        OP_MUL_PE,
        OP_ACC_P,
        OP_MUL_GIP,
        OP_MUL_IE,
        OP_ACC_I,
        OP_MUL_D,
        OP_ACC_D,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_COMMIT,
        OP_ZERO
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEP,
        ST_INTEG,
        ST_GPP,
        ST_PE,
        ST_ACCP,
        ST_GIP,
        ST_IE,
        ST_ACCI,
        ST_MULD,
        ST_ACCD,
        ST_DIVI,
        ST_DIV,
        ST_COMMIT,
        ST_ZERO
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic out_free;
    } status_t;

endpackage

FILE: src/pidtr_ctrl.sv
module pidtr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pidtr_pkg::status_t status,
    output pidtr_pkg::cmd_t    cmd
);

    pidtr_pkg::state_t state_reg, state_next;
    logic [pidtr_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pidtr_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = pidtr_pkg::OP_NONE;
        s_ready      = 1'b0;
        case (state_reg)
            pidtr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status.enabled) begin
                        cmd.op     = pidtr_pkg::OP_LOAD;
                        state_next = pidtr_pkg::ST_MEP;
                    end else begin
                        state_next = pidtr_pkg::ST_ZERO;
                    end
                end
            end
            pidtr_pkg::ST_MEP: begin
                cmd.op     = pidtr_pkg::OP_MUL_EP;
                state_next = pidtr_pkg::ST_INTEG;
            end
            pidtr_pkg::ST_INTEG: begin
                cmd.op     = pidtr_pkg::OP_INTEG;
                state_next = pidtr_pkg::ST_GPP;
            end
            pidtr_pkg::ST_GPP: begin
                cmd.op     = pidtr_pkg::OP_MUL_GPP;
                state_next = pidtr_pkg::ST_PE;
            end
            pidtr_pkg::ST_PE: begin
                cmd.op     = pidtr_pkg::OP_MUL_PE;
                state_next = pidtr_pkg::ST_ACCP;
            end
            pidtr_pkg::ST_ACCP: begin
                cmd.op     = pidtr_pkg::OP_ACC_P;
                state_next = pidtr_pkg::ST_GIP;
            end
            pidtr_pkg::ST_GIP: begin
                cmd.op     = pidtr_pkg::OP_MUL_GIP;
                state_next = pidtr_pkg::ST_IE;
            end
            pidtr_pkg::ST_IE: begin
                cmd.op     = pidtr_pkg::OP_MUL_IE;
                state_next = pidtr_pkg::ST_ACCI;
            end
            pidtr_pkg::ST_ACCI: begin
                cmd.op     = pidtr_pkg::OP_ACC_I;
                state_next = pidtr_pkg::ST_MULD;
            end
            pidtr_pkg::ST_MULD: begin
                cmd.op     = pidtr_pkg::OP_MUL_D;
                state_next = pidtr_pkg::ST_ACCD;
            end
            pidtr_pkg::ST_ACCD: begin
                cmd.op     = pidtr_pkg::OP_ACC_D;
                state_next = pidtr_pkg::ST_DIVI;
            end
            pidtr_pkg::ST_DIVI: begin
                cmd.op       = pidtr_pkg::OP_DIV_INIT;
                div_cnt_next = pidtr_pkg::DIV_CNT_W'(pidtr_pkg::DIV_STEPS - 1);
                state_next   = pidtr_pkg::ST_DIV;
            end
            pidtr_pkg::ST_DIV: begin
                cmd.op = pidtr_pkg::OP_DIV_STEP;
                if (div_cnt_reg == '0) begin
                    state_next = pidtr_pkg::ST_COMMIT;
                end else begin
                    div_cnt_next = div_cnt_reg - pidtr_pkg::DIV_CNT_W'(1);
                end
            end
            pidtr_pkg::ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.op     = pidtr_pkg::OP_COMMIT;
                    state_next = pidtr_pkg::ST_IDLE;
                end
            end
            pidtr_pkg::ST_ZERO: begin
                if (status.out_free) begin
                    cmd.op     = pidtr_pkg::OP_ZERO;
                    state_next = pidtr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pidtr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/pidtr_dp.sv
module pidtr_dp #(
    parameter logic [pidtr_pkg::SP_W-1:0] SETPOINT_MIN = pidtr_pkg::SETPOINT_MIN,
    parameter logic [pidtr_pkg::SP_W-1:0] SETPOINT_MAX = pidtr_pkg::SETPOINT_MAX
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pidtr_pkg::cmd_t                        cmd,
    output pidtr_pkg::status_t                     status,
    input  logic signed [pidtr_pkg::TEMP_W-1:0]    s_temp_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [pidtr_pkg::DUTY_W-1:0]           m_heater_duty,
    input  logic                                   cfg_wr,
    input  logic [pidtr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidtr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic run_en_reg, run_en_next;
    logic gains_ok_reg, gains_ok_next;
    logic [pidtr_pkg::SP_W-1:0]     target_reg, target_next;
    logic [pidtr_pkg::GP_W-1:0]     gp_reg, gp_next;
    logic [pidtr_pkg::GI_W-1:0]     gi_reg, gi_next;
    logic [pidtr_pkg::GD_W-1:0]     gd_reg, gd_next;
    logic [pidtr_pkg::PERIOD_W-1:0] period_reg, period_next;

    logic signed [pidtr_pkg::INTEG_W-1:0] integral_reg, integral_next;
    logic signed [pidtr_pkg::ERR_W-1:0]   last_err_reg, last_err_next;

    logic signed [pidtr_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [pidtr_pkg::DERR_W-1:0]  derr_reg, derr_next;
    logic signed [pidtr_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [pidtr_pkg::INTEG_W-1:0] integ_reg, integ_next;
    logic signed [pidtr_pkg::ACC_W-1:0]   acc_reg, acc_next;

    logic [pidtr_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [pidtr_pkg::DSOR_W-1:0]  dsor_reg, dsor_next;
    logic [pidtr_pkg::DUTY_W-1:0]  quot_reg, quot_next;
    logic ovf_reg, ovf_next;
    logic nonpos_reg, nonpos_next;

    logic [pidtr_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic m_valid_reg, m_valid_next;

    logic [pidtr_pkg::PERIOD_W-1:0]       period_eff;
    logic signed [pidtr_pkg::ERR_W-1:0]   err_calc;
    logic signed [pidtr_pkg::DERR_W-1:0]  derr_calc;
    logic signed [pidtr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pidtr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pidtr_pkg::MUL_A_W+pidtr_pkg::MUL_B_W-1:0] mul_p;
    logic signed [pidtr_pkg::PROD_W:0]    isum;
    logic signed [pidtr_pkg::ACC_W-1:0]   prod_ext;
    logic [pidtr_pkg::REM_W-1:0]          n_shift;
    logic                                 rem_ge;
    logic [pidtr_pkg::SP_W-1:0]           sp_in;

    assign period_eff = (period_reg == '0) ? pidtr_pkg::PERIOD_W'(1) : period_reg;
    assign err_calc   = $signed({4'b0, target_reg})
                      - $signed({s_temp_sample[pidtr_pkg::TEMP_W-1], s_temp_sample});
    assign derr_calc  = $signed({err_calc[pidtr_pkg::ERR_W-1], err_calc})
                      - $signed({last_err_reg[pidtr_pkg::ERR_W-1], last_err_reg});
    assign mul_p      = mul_a * mul_b;
    assign isum       = $signed({{(pidtr_pkg::PROD_W+1-pidtr_pkg::INTEG_W)
                                  {integral_reg[pidtr_pkg::INTEG_W-1]}}, integral_reg})
                      + $signed({prod_reg[pidtr_pkg::PROD_W-1], prod_reg});
    assign prod_ext   = $signed({{(pidtr_pkg::ACC_W-pidtr_pkg::PROD_W)
                                  {prod_reg[pidtr_pkg::PROD_W-1]}}, prod_reg});
    assign n_shift    = acc_reg[pidtr_pkg::ACC_W-1:12];
    assign rem_ge     = rem_reg >= pidtr_pkg::REM_W'(dsor_reg);
    assign sp_in      = cfg_data[pidtr_pkg::SP_W-1:0];

    assign status.enabled  = run_en_reg & gains_ok_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_heater_duty   = duty_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pidtr_pkg::OP_MUL_EP: begin
                mul_a = {{(pidtr_pkg::MUL_A_W-pidtr_pkg::ERR_W){err_reg[pidtr_pkg::ERR_W-1]}},
                         err_reg};
                mul_b = {4'b0, period_eff};
            end
            pidtr_pkg::OP_MUL_GPP: begin
                mul_a = {17'b0, gp_reg};
                mul_b = {4'b0, period_eff};
            end
            pidtr_pkg::OP_MUL_PE: begin
                mul_a = prod_reg[pidtr_pkg::MUL_A_W-1:0];
                mul_b = {{(pidtr_pkg::MUL_B_W-pidtr_pkg::ERR_W){err_reg[pidtr_pkg::ERR_W-1]}},
                         err_reg};
            end
            pidtr_pkg::OP_MUL_GIP: begin
                mul_a = {20'b0, gi_reg};
                mul_b = {4'b0, period_eff};
            end
            pidtr_pkg::OP_MUL_IE: begin
                mul_a = prod_reg[pidtr_pkg::MUL_A_W-1:0];
                mul_b = integ_reg;
            end
            pidtr_pkg::OP_MUL_D: begin
                mul_a = {18'b0, gd_reg};
                mul_b = {{(pidtr_pkg::MUL_B_W-pidtr_pkg::DERR_W)
                          {derr_reg[pidtr_pkg::DERR_W-1]}}, derr_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        run_en_next   = run_en_reg;
        gains_ok_next = gains_ok_reg;
        target_next   = target_reg;
        gp_next       = gp_reg;
        gi_next       = gi_reg;
        gd_next       = gd_reg;
        period_next   = period_reg;
        integral_next = integral_reg;
        last_err_next = last_err_reg;
        err_next      = err_reg;
        derr_next     = derr_reg;
        prod_next     = prod_reg;
        integ_next    = integ_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        dsor_next     = dsor_reg;
        quot_next     = quot_reg;
        ovf_next      = ovf_reg;
        nonpos_next   = nonpos_reg;
        duty_next     = duty_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (cmd.op)
            pidtr_pkg::OP_LOAD: begin
                err_next  = err_calc;
                derr_next = derr_calc;
            end
            pidtr_pkg::OP_MUL_EP, pidtr_pkg::OP_MUL_GPP, pidtr_pkg::OP_MUL_PE,
            pidtr_pkg::OP_MUL_GIP, pidtr_pkg::OP_MUL_IE, pidtr_pkg::OP_MUL_D: begin
                prod_next = mul_p[pidtr_pkg::PROD_W-1:0];
            end
            pidtr_pkg::OP_INTEG: begin
                if (isum > $signed((pidtr_pkg::PROD_W+1)'(pidtr_pkg::INTEG_LIMIT))) begin
                    integ_next = pidtr_pkg::INTEG_LIMIT;
                end else if (isum < -$signed((pidtr_pkg::PROD_W+1)'(pidtr_pkg::INTEG_LIMIT)))
                begin
                    integ_next = -pidtr_pkg::INTEG_LIMIT;
                end else begin
                    integ_next = isum[pidtr_pkg::INTEG_W-1:0];
                end
            end
            pidtr_pkg::OP_ACC_P: begin
                acc_next = prod_ext <<< 8;
            end
            pidtr_pkg::OP_ACC_I: begin
                acc_next = acc_reg + prod_ext;
            end
            pidtr_pkg::OP_ACC_D: begin
                acc_next = acc_reg + (prod_ext <<< 16);
            end
            pidtr_pkg::OP_DIV_INIT: begin
                // sum/(4096*T) == (sum>>12)/T for a positive sum
                nonpos_next = acc_reg[pidtr_pkg::ACC_W-1] || (acc_reg == '0);
                rem_next    = n_shift;
                ovf_next    = n_shift >= pidtr_pkg::REM_W'({period_eff, {pidtr_pkg::DIV_STEPS{1'b0}}});
                dsor_next   = {period_eff, {(pidtr_pkg::DIV_STEPS-1){1'b0}}};
                quot_next   = '0;
            end
            pidtr_pkg::OP_DIV_STEP: begin
                if (rem_ge) begin
                    rem_next = rem_reg - pidtr_pkg::REM_W'(dsor_reg);
                end
                quot_next = {quot_reg[pidtr_pkg::DUTY_W-2:0], rem_ge};
                dsor_next = dsor_reg >> 1;
            end
            pidtr_pkg::OP_COMMIT: begin
                if (nonpos_reg) begin
                    duty_next = '0;
                end else if (ovf_reg || (quot_reg > pidtr_pkg::DUTY_MAX)) begin
                    duty_next = pidtr_pkg::DUTY_MAX;
                end else begin
                    duty_next = quot_reg;
                end
                integral_next = integ_reg;
                last_err_next = err_reg;
                m_valid_next  = 1'b1;
            end
            pidtr_pkg::OP_ZERO: begin
                duty_next    = '0;
                m_valid_next = 1'b1;
            end
            default: begin
            end
        endcase

        if (cfg_wr) begin
            case (cfg_index)
                pidtr_pkg::CFG_RUN_ENABLE: begin
                    run_en_next = cfg_data[0];
                    if (!cfg_data[0]) begin
                        integral_next = '0;
                        last_err_next = '0;
                    end
                end
                pidtr_pkg::CFG_GAINS_VALID: gains_ok_next = cfg_data[0];
                pidtr_pkg::CFG_TARGET_TEMP: begin
                    if (sp_in > SETPOINT_MAX) begin
                        target_next = SETPOINT_MAX;
                    end else if (sp_in < SETPOINT_MIN) begin
                        target_next = SETPOINT_MIN;
                    end else begin
                        target_next = sp_in;
                    end
                end
                pidtr_pkg::CFG_GAIN_P:        gp_next     = cfg_data[pidtr_pkg::GP_W-1:0];
                pidtr_pkg::CFG_GAIN_I:        gi_next     = cfg_data[pidtr_pkg::GI_W-1:0];
                pidtr_pkg::CFG_GAIN_D:        gd_next     = cfg_data[pidtr_pkg::GD_W-1:0];
                pidtr_pkg::CFG_SAMPLE_PERIOD: period_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_en_reg   <= 1'b0;
            gains_ok_reg <= 1'b0;
            target_reg   <= pidtr_pkg::TARGET_RESET;
            gp_reg       <= '0;
            gi_reg       <= '0;
            gd_reg       <= '0;
            period_reg   <= pidtr_pkg::PERIOD_RESET;
            integral_reg <= '0;
            last_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            run_en_reg   <= run_en_next;
            gains_ok_reg <= gains_ok_next;
            target_reg   <= target_next;
            gp_reg       <= gp_next;
            gi_reg       <= gi_next;
            gd_reg       <= gd_next;
            period_reg   <= period_next;
            integral_reg <= integral_next;
            last_err_reg <= last_err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        derr_reg   <= derr_next;
        prod_reg   <= prod_next;
        integ_reg  <= integ_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        dsor_reg   <= dsor_next;
        quot_reg   <= quot_next;
        ovf_reg    <= ovf_next;
        nonpos_reg <= nonpos_next;
        duty_reg   <= duty_next;
    end

endmodule

FILE: src/pid_temperature_regulator_top.sv
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_temp_sample  (16b signed, 1/16 C)
// m_        out        m_valid / m_ready    m_heater_duty  (15b, 1/256 %)
// cfg_      in         cfg_valid/cfg_ready  cfg_index (3b), cfg_data (16b)
//
// Enabled sample: the result is computed by the shared
// 32x20 multiplier sequence (10 steps) and a 15-step restoring divider.
// Disabled or gains not valid: a zero duty is written via ST_ZERO instead.
// The result register holds one transaction; a stalled m_ready blocks only
// the final write-back. Synchronous active-low reset; cfg_ready is always high.
module pid_temperature_regulator_top #(
    parameter logic [pidtr_pkg::SP_W-1:0] SETPOINT_MIN = pidtr_pkg::SETPOINT_MIN,
    parameter logic [pidtr_pkg::SP_W-1:0] SETPOINT_MAX = pidtr_pkg::SETPOINT_MAX
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pidtr_pkg::TEMP_W-1:0] s_temp_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pidtr_pkg::DUTY_W-1:0]        m_heater_duty,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidtr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidtr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pidtr_pkg::cmd_t    cmd;
    pidtr_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pidtr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pidtr_dp #(
        .SETPOINT_MIN (SETPOINT_MIN),
        .SETPOINT_MAX (SETPOINT_MAX)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_temp_sample (s_temp_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heater_duty (m_heater_duty),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

FILE: src/pidtr_checker.sv
module pidtr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [pidtr_pkg::DUTY_W-1:0]     m_heater_duty
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heater_duty))
        else $error("result changed while stalled");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_heater_duty <= pidtr_pkg::DUTY_MAX)
        else $error("duty above limit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind pid_temperature_regulator_top pidtr_checker u_pidtr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_heater_duty (m_heater_duty)
);
